// ===== design/skt_pkg.sv =====
package skt_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 16;
   localparam int STATUS_W   = 3;
   localparam int POSITION_W = 6;
   localparam int COUNT_W    = 7;

   // Request function codes.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

   typedef struct packed {
      logic               func;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    entry_count;
   } rsp_type;

   // Flags that one cell reports to the control logic.
   typedef struct packed {
      logic lt;   // held key is below the search key
      logic eq;   // held key matches the search key
      logic ins;  // this slot receives the new entry on insert
   } cell_flags_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

// ===== design/skt_cell.sv =====
module skt_cell #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       capture,
   input  logic                       occupied,
   input  logic [KEY_WIDTH-1:0]       cmp_key,
   input  logic                       write,
   input  logic [KEY_WIDTH-1:0]       new_key,
   input  logic [VALUE_WIDTH-1:0]     new_value,
   input  logic [KEY_WIDTH-1:0]       left_key,
   input  logic [VALUE_WIDTH-1:0]     left_value,
   input  logic                       left_lt,
   output logic [KEY_WIDTH-1:0]       key,
   output logic [VALUE_WIDTH-1:0]     value,
   output skt_pkg::cell_flags_type    flags
);

   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   lt_ff, lt_in;
   logic                   eq_ff, eq_in;
   logic                   ins;

   // Compare the held key against the incoming search key.
   assign lt_in = occupied && (key_ff < cmp_key);
   assign eq_in = occupied && (key_ff == cmp_key);

   // The first slot whose key is not below the search key takes the new entry;
   // every slot above it takes its left neighbor's entry.
   assign ins = left_lt && !lt_ff;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ins) begin
         key_in   = new_key;
         value_in = new_value;
      end else if (!lt_ff) begin
         key_in   = left_key;
         value_in = left_value;
      end
   end

   // Entry storage and captured compare flags.
   always_ff @(posedge clock) begin
      if (capture) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      if (write) begin
         key_ff   <= key_in;
         value_ff <= value_in;
      end
   end

   assign key       = key_ff;
   assign value     = value_ff;
   assign flags.lt  = lt_ff;
   assign flags.eq  = eq_ff;
   assign flags.ins = ins;

endmodule

// ===== design/sorted_key_table.sv =====
// Sorted key table: a row of CAPACITY cells holds key/value entries in strictly
// ascending key order. A request either inserts a key with its value or looks
// up a key, and each request yields exactly one response with a status, the
// key's sorted slot and the entry count after the request. In the accept cycle
// all cells compare their key with the request key in parallel and capture the
// result; in the execute state the response is formed and, on an insert, every
// cell above the insertion slot takes its neighbor's entry at the edge that
// registers the response. The execute state waits only while an earlier
// response is still held in the output register and not taken. A request can
// be accepted while a finished response waits to be taken. Inserting a key
// that is already held reports its slot and changes nothing; inserting a new
// key into a full table reports table full. Entries need no clearing after reset.
module sorted_key_table #(
   parameter int CAPACITY    = 64,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  skt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output skt_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = $clog2(CAPACITY);

   skt_pkg::state_type     state_ff, state_in;
   logic                   func_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   skt_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   finish;
   logic                   hit;
   logic                   full;
   logic                   do_insert;
   logic [KEY_WIDTH-1:0]   cmp_key;
   logic [PW-1:0]          pos_enc;
   logic [CAPACITY-1:0]    eq_vec;
   logic [CAPACITY-1:0]    ins_vec;
   logic [CAPACITY-1:0]    lt_vec;

   logic [KEY_WIDTH-1:0]       cell_key   [CAPACITY];
   logic [VALUE_WIDTH-1:0]     cell_value [CAPACITY];
   skt_pkg::cell_flags_type    cell_flags [CAPACITY];

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cmp_key  = KEY_WIDTH'(req_data.key);

   // Row of cells; slot zero sees an always-lower left neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0]   left_key;
      logic [VALUE_WIDTH-1:0] left_value;
      logic                   left_lt;

      if (i == 0) begin : g_first
         assign left_key   = '0;
         assign left_value = '0;
         assign left_lt    = 1'b1;
      end else begin : g_rest
         assign left_key   = cell_key[i-1];
         assign left_value = cell_value[i-1];
         assign left_lt    = lt_vec[i-1];
      end

      skt_cell #(
         .KEY_WIDTH   (KEY_WIDTH),
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .capture    (req_fire),
         .occupied   (count_ff > CW'(i)),
         .cmp_key    (cmp_key),
         .write      (do_insert),
         .new_key    (key_ff),
         .new_value  (value_ff),
         .left_key   (left_key),
         .left_value (left_value),
         .left_lt    (left_lt),
         .key        (cell_key[i]),
         .value      (cell_value[i]),
         .flags      (cell_flags[i])
      );

      assign lt_vec[i]  = cell_flags[i].lt;
      assign eq_vec[i]  = cell_flags[i].eq;
      assign ins_vec[i] = cell_flags[i].ins;
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skt_pkg::S_IDLE: begin
            if (req_valid) state_in = skt_pkg::S_EXEC;
         end
         skt_pkg::S_EXEC: begin
            if (out_free) state_in = skt_pkg::S_IDLE;
         end
         default: state_in = skt_pkg::S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         skt_pkg::S_IDLE: req_ready = 1'b1;
         skt_pkg::S_EXEC: finish    = out_free;
         default: begin
            req_ready = 1'b0;
            finish    = 1'b0;
         end
      endcase
   end

   // Match and insertion decisions from the captured cell flags.
   assign hit       = |eq_vec;
   assign full      = (count_ff == CW'(CAPACITY));
   assign do_insert = finish && (func_ff == skt_pkg::FUNC_INSERT) && !hit && !full;
   assign count_in  = count_ff + CW'(do_insert);

   // The matching slot or the insertion slot is one-hot; encode it.
   always_comb begin
      pos_enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit ? eq_vec[i] : ins_vec[i]) pos_enc = pos_enc | PW'(i);
      end
   end

   // Response fields.
   always_comb begin
      rsp_data_in             = rsp_data_ff;
      rsp_data_in.entry_count = skt_pkg::COUNT_W'(count_in);
      rsp_data_in.position    = skt_pkg::POSITION_W'(pos_enc);
      if (func_ff == skt_pkg::FUNC_LOOKUP) begin
         if (hit) begin
            rsp_data_in.status = skt_pkg::STATUS_FOUND;
         end else begin
            rsp_data_in.status   = skt_pkg::STATUS_NOT_FOUND;
            rsp_data_in.position = '0;
         end
      end else if (hit) begin
         rsp_data_in.status = skt_pkg::STATUS_PRESENT;
      end else if (full) begin
         rsp_data_in.status   = skt_pkg::STATUS_FULL;
         rsp_data_in.position = '0;
      end else begin
         rsp_data_in.status = skt_pkg::STATUS_INSERTED;
      end
   end

   // Output register handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skt_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_data.func;
         key_ff   <= cmp_key;
         value_ff <= VALUE_WIDTH'(req_data.value);
      end
      if (finish) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
